### hdl/vnorm_pkg.sv
// shared types and constants for the vector norm unit
package vnorm_pkg;

    // field and state widths
    localparam int unsigned PIXEL_W = 8;
    localparam int unsigned TOTAL_W = 41;
    localparam int unsigned OUT_W   = 48;
    localparam int unsigned MODE_W  = 2;

    // parameter defaults
    localparam int unsigned DEF_MAX_ELEMENTS  = 16777216;
    localparam int unsigned DEF_FRACTION_BITS = 16;

    // norm mode codes; the unused code behaves as maximum
    localparam logic [MODE_W-1:0] MODE_L1  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_L2  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MAX = 2'd2;

    // sequencer states
    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_SQRT,
        ST_DELIVER
    } t_state;

endpackage

### hdl/vector_norm_l1_l2_inf_unit.sv
// vector norm unit (l1 sum, l2 root of sum of squares, maximum) over a sample stream
// Usage: samples enter on the s-channel, one 8-bit sample per item in s_tdata,
// with s_tlast on the last sample of a frame. The mode register (cfg_wr_en,
// cfg_wr_data) picks the measure; the user must write it only while the block is
// idle, as the block has no check for it. One result per frame leaves on the
// m-channel: m_tdata carries the norm in unsigned fixed point with FRACTION_BITS
// fraction bits, m_tuser the saturation flag. Samples that are not last go to the
// accumulator at one per cycle while no root result is pending. A last sample in l1 or
// maximum mode puts its result in the output register, valid from the next cycle.
// A last sample in l2 mode starts the restoring square-root step, one result bit
// per cycle for 21 + FRACTION_BITS bits, then delivers once the output register is
// free; s_tready is low during that time. The result sits in an output register:
// the block keeps taking samples while it waits, but holds off a last sample until
// that register is free. Reset clears the mode to l1, the running total, the overflow
// flag and the output valid; a stalled receiver only holds the result in place.
module vector_norm_l1_l2_inf_unit #(
    parameter int unsigned MAX_ELEMENTS  = vnorm_pkg::DEF_MAX_ELEMENTS,
    parameter int unsigned FRACTION_BITS = vnorm_pkg::DEF_FRACTION_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: norm mode
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_wr_data,
    // sample stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] pixel_value
    input  logic        i_s_tlast,   // last_element
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // [47:0] norm_value
    output logic [0:0]  o_m_tuser    // [0] saturated
);

    localparam int unsigned TW = vnorm_pkg::TOTAL_W;
    localparam int unsigned OW = vnorm_pkg::OUT_W;

    // clamp limits of the running total
    localparam logic [63:0] TOTAL_MAX64 = (64'd1 << TW) - 64'd1;
    localparam logic [63:0] L1_RAW64    = 64'(MAX_ELEMENTS) * 64'd255;
    localparam logic [63:0] L2_RAW64    = 64'(MAX_ELEMENTS) * 64'd65025;
    localparam logic [63:0] CAP_L1_64   = (L1_RAW64 > TOTAL_MAX64) ? TOTAL_MAX64 : L1_RAW64;
    localparam logic [63:0] CAP_L2_64   = (L2_RAW64 > TOTAL_MAX64) ? TOTAL_MAX64 : L2_RAW64;
    localparam logic [TW-1:0] CAP_L1    = CAP_L1_64[TW-1:0];
    localparam logic [TW-1:0] CAP_L2    = CAP_L2_64[TW-1:0];

    // largest total that still fits the output after scaling
    localparam logic [OW-1:0] OUT_ONES  = {OW{1'b1}};
    localparam logic [OW-1:0] OUT_LIMIT = OUT_ONES >> FRACTION_BITS;

    // square-root sequencer sizes
    localparam int unsigned STEPS = 21 + FRACTION_BITS;
    localparam int unsigned RAD_W = 2 * STEPS;
    localparam int unsigned REM_W = STEPS + 2;
    localparam int unsigned CNT_W = $clog2(STEPS);
    localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(STEPS - 1);

    vnorm_pkg::t_state r_state, n_state;
    logic [1:0]       r_mode;
    logic [TW-1:0]    r_total, n_total;
    logic             r_ovf, n_ovf;
    logic [RAD_W-1:0] r_rad, n_rad;
    logic [REM_W-1:0] r_rem, n_rem;
    logic [STEPS-1:0] r_root, n_root;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_sqrt_sat, n_sqrt_sat;
    logic             r_out_valid, n_out_valid;
    logic [OW-1:0]    r_out_norm, n_out_norm;
    logic             r_out_sat, n_out_sat;

    logic             s_acc;
    logic             out_free;
    logic [15:0]      acc_add;
    logic [TW:0]      acc_sum;
    logic [TW-1:0]    acc_cap;
    logic [TW-1:0]    acc_total;
    logic             acc_ovf;
    logic [REM_W-1:0] sq_rem_sh;
    logic [REM_W-1:0] sq_trial;

    // handshake
    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == vnorm_pkg::ST_ACCUM) && (!i_s_tlast || out_free);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_norm;
    assign o_m_tuser  = r_out_sat;

    // accumulator: sum or sum of squares, both clamped, or maximum
    always_comb begin
        acc_add   = 16'(i_s_tdata) * 16'(i_s_tdata);
        acc_cap   = CAP_L2;
        acc_sum   = '0;
        acc_total = r_total;
        acc_ovf   = r_ovf;
        unique case (r_mode)
            vnorm_pkg::MODE_L1, vnorm_pkg::MODE_L2: begin
                if (r_mode == vnorm_pkg::MODE_L1) begin
                    acc_add = 16'(i_s_tdata);
                    acc_cap = CAP_L1;
                end
                acc_sum = {1'b0, r_total} + (TW + 1)'(acc_add);
                if (acc_sum > {1'b0, acc_cap}) begin
                    acc_total = acc_cap;
                    acc_ovf   = 1'b1;
                end else begin
                    acc_total = acc_sum[TW-1:0];
                end
            end
            default: begin
                if (TW'(i_s_tdata) > r_total) begin
                    acc_total = TW'(i_s_tdata);
                end
            end
        endcase
    end

    // one restoring square-root step
    assign sq_rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
    assign sq_trial  = {r_root, 2'b01};

    // sequencer: next state and datapath updates
    always_comb begin
        n_state     = r_state;
        n_total     = r_total;
        n_ovf       = r_ovf;
        n_rad       = r_rad;
        n_rem       = r_rem;
        n_root      = r_root;
        n_cnt       = r_cnt;
        n_sqrt_sat  = r_sqrt_sat;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_norm  = r_out_norm;
        n_out_sat   = r_out_sat;
        unique case (r_state)
            vnorm_pkg::ST_ACCUM: begin
                if (s_acc) begin
                    n_total = acc_total;
                    n_ovf   = acc_ovf;
                    if (i_s_tlast) begin
                        n_total = '0;
                        n_ovf   = 1'b0;
                        if (r_mode == vnorm_pkg::MODE_L2) begin
                            n_rad      = RAD_W'(acc_total) << (2 * FRACTION_BITS);
                            n_rem      = '0;
                            n_root     = '0;
                            n_cnt      = CNT_LOAD;
                            n_sqrt_sat = acc_ovf;
                            n_state    = vnorm_pkg::ST_SQRT;
                        end else begin
                            n_out_valid = 1'b1;
                            if ({7'b0, acc_total} > OUT_LIMIT) begin
                                n_out_norm = OUT_ONES;
                                n_out_sat  = 1'b1;
                            end else begin
                                n_out_norm = OW'(acc_total) << FRACTION_BITS;
                                n_out_sat  = acc_ovf;
                            end
                        end
                    end
                end
            end
            vnorm_pkg::ST_SQRT: begin
                n_rad = r_rad << 2;
                if (sq_rem_sh >= sq_trial) begin
                    n_rem  = sq_rem_sh - sq_trial;
                    n_root = {r_root[STEPS-2:0], 1'b1};
                end else begin
                    n_rem  = sq_rem_sh;
                    n_root = {r_root[STEPS-2:0], 1'b0};
                end
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = vnorm_pkg::ST_DELIVER;
                end
            end
            vnorm_pkg::ST_DELIVER: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_norm  = OW'(r_root);
                    n_out_sat   = r_sqrt_sat;
                    n_state     = vnorm_pkg::ST_ACCUM;
                end
            end
            default: begin
                n_state = vnorm_pkg::ST_ACCUM;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vnorm_pkg::ST_ACCUM;
            r_mode      <= vnorm_pkg::MODE_L1;
            r_total     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_rad      <= n_rad;
        r_rem      <= n_rem;
        r_root     <= n_root;
        r_cnt      <= n_cnt;
        r_sqrt_sat <= n_sqrt_sat;
        r_out_norm <= n_out_norm;
        r_out_sat  <= n_out_sat;
    end

    // checks
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != vnorm_pkg::ST_ACCUM) |-> !o_s_tready)
        else $error("sample taken while the root step is busy");

    a_frame_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && i_s_tlast) |=> (r_total == '0 && !r_ovf))
        else $error("running total not cleared after the last sample");

    a_total_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == vnorm_pkg::MODE_L1 || r_mode == vnorm_pkg::MODE_L2)
        && s_acc |=> (r_total <= CAP_L2))
        else $error("running total above its clamp");

    a_direct_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && i_s_tlast && r_mode != vnorm_pkg::MODE_L2) |=> o_m_tvalid)
        else $error("no result after a last sample");

endmodule

### verif/tb.sv
// self-checking testbench for the vector norm unit: directed and random frames, scored per result
`timescale 1ns / 100ps

module tb;

    // block configuration as instantiated
    localparam int unsigned FRAC   = vnorm_pkg::DEF_FRACTION_BITS;
    localparam int unsigned MAX_EL = vnorm_pkg::DEF_MAX_ELEMENTS;

    // spare mode code, behaves as maximum
    localparam logic [vnorm_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

    // limits of the running total and of the result
    localparam logic [63:0] TOTAL_MAX  = (64'd1 << vnorm_pkg::TOTAL_W) - 64'd1;
    localparam logic [63:0] OUT_MAX    = (64'd1 << vnorm_pkg::OUT_W) - 64'd1;
    localparam logic [63:0] L1_CAP_RAW = 64'(MAX_EL) * 64'd255;
    localparam logic [63:0] L2_CAP_RAW = 64'(MAX_EL) * 64'd65025;
    localparam logic [63:0] L1_CAP = (L1_CAP_RAW > TOTAL_MAX) ? TOTAL_MAX : L1_CAP_RAW;
    localparam logic [63:0] L2_CAP = (L2_CAP_RAW > TOTAL_MAX) ? TOTAL_MAX : L2_CAP_RAW;

    // worst block latency (root plus delivery) with margin
    localparam int unsigned SETTLE_CYCLES = 2 * (vnorm_pkg::TOTAL_W / 2 + 1 + FRAC + 1);
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned PHASE_ITEMS   = 250;

    typedef struct packed {
        logic [vnorm_pkg::OUT_W-1:0] norm;
        logic                        sat;
    } t_norm_result;

    typedef struct packed {
        logic                         cfg_en;
        logic [vnorm_pkg::MODE_W-1:0] mode;
        logic [7:0]                   px;
        logic                         last;
        logic                         known;
        logic [vnorm_pkg::OUT_W-1:0]  norm;
    } t_dir_row;

    // directed rows: optional mode write before the item, then the item
    localparam int N_ROWS = 22;
    localparam t_dir_row DIRECTED [N_ROWS] = '{
        // cfg   mode                 px      last  known norm
        '{1'b0, vnorm_pkg::MODE_L1,  8'd0,   1'b1, 1'b1, 48'h0},       // empty sum after reset
        '{1'b0, vnorm_pkg::MODE_L1,  8'd255, 1'b1, 1'b1, 48'hFF_0000},
        '{1'b0, vnorm_pkg::MODE_L1,  8'd255, 1'b0, 1'b0, 48'h0},
        '{1'b0, vnorm_pkg::MODE_L1,  8'd255, 1'b1, 1'b1, 48'h1FE_0000},
        '{1'b1, vnorm_pkg::MODE_L2,  8'd255, 1'b1, 1'b1, 48'hFF_0000},
        '{1'b0, vnorm_pkg::MODE_L2,  8'd0,   1'b1, 1'b1, 48'h0},
        '{1'b0, vnorm_pkg::MODE_L2,  8'd3,   1'b0, 1'b0, 48'h0},
        '{1'b0, vnorm_pkg::MODE_L2,  8'd4,   1'b1, 1'b1, 48'h5_0000},
        '{1'b0, vnorm_pkg::MODE_L2,  8'd1,   1'b0, 1'b0, 48'h0},
        '{1'b0, vnorm_pkg::MODE_L2,  8'd1,   1'b1, 1'b0, 48'h0},       // truncated root of two
        '{1'b1, vnorm_pkg::MODE_MAX, 8'd7,   1'b0, 1'b0, 48'h0},
        '{1'b0, vnorm_pkg::MODE_MAX, 8'd200, 1'b0, 1'b0, 48'h0},
        '{1'b0, vnorm_pkg::MODE_MAX, 8'd9,   1'b1, 1'b1, 48'hC8_0000},
        '{1'b0, vnorm_pkg::MODE_MAX, 8'd0,   1'b1, 1'b1, 48'h0},
        '{1'b0, vnorm_pkg::MODE_MAX, 8'd255, 1'b1, 1'b1, 48'hFF_0000},
        '{1'b1, MODE_SPARE,          8'd5,   1'b0, 1'b0, 48'h0},       // unused code acts as max
        '{1'b0, MODE_SPARE,          8'd17,  1'b1, 1'b1, 48'h11_0000},
        '{1'b1, vnorm_pkg::MODE_L1,  8'd100, 1'b0, 1'b0, 48'h0},
        '{1'b1, vnorm_pkg::MODE_MAX, 8'd50,  1'b1, 1'b1, 48'h64_0000}, // mode change inside a frame
        '{1'b1, vnorm_pkg::MODE_L1,  8'd10,  1'b0, 1'b0, 48'h0},
        '{1'b1, vnorm_pkg::MODE_L2,  8'd3,   1'b1, 1'b0, 48'h0},       // sum then squares, one frame
        '{1'b1, vnorm_pkg::MODE_L1,  8'd128, 1'b1, 1'b1, 48'h80_0000}
    };

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_wr_en   = 1'b0;
    logic [1:0]        i_cfg_wr_data = '0;
    logic              i_s_tvalid    = 1'b0;
    logic              o_s_tready;
    logic [7:0]        i_s_tdata     = '0;
    logic              i_s_tlast     = 1'b0;
    logic              o_m_tvalid;
    logic              i_m_tready    = 1'b0;
    logic [47:0]       o_m_tdata;
    logic [0:0]        o_m_tuser;

    // predictor state
    logic [vnorm_pkg::MODE_W-1:0] norm_mode_q = vnorm_pkg::MODE_L1;
    logic [63:0]       total_q     = '0;
    logic              clamped_q   = 1'b0;

    t_norm_result      expected_norms [$];
    t_norm_result      head_norm;
    logic              failed         = 1'b0;
    int unsigned       src_idle_pct   = 0;
    int unsigned       sink_stall_pct = 0;
    logic              hold_req       = 1'b0;
    int unsigned       hold_left      = 0;

    vector_norm_l1_l2_inf_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tlast     (i_s_tlast),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // restoring square root of total scaled by 2^(2*FRAC), truncated
    function automatic logic [63:0] fixed_root(input logic [63:0] total);
        logic [127:0] radicand;
        logic [127:0] rem;
        logic [127:0] trial;
        logic [63:0]  root;
        radicand = 128'(total) << (2 * FRAC);
        rem      = '0;
        root     = '0;
        for (int i = vnorm_pkg::TOTAL_W / 2 + FRAC; i >= 0; i--) begin
            rem   = (rem << 2) | ((radicand >> (2 * i)) & 128'd3);
            trial = (128'(root) << 2) | 128'd1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root << 1) | 64'd1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    // accumulate one sample; on the last one form the norm and clear
    function automatic logic predict_norm(input logic [7:0] px, input logic last,
                                          output t_norm_result res);
        logic [63:0] sum;
        logic [63:0] cap;
        logic [63:0] val;
        logic        sat;
        res = '0;
        if (norm_mode_q == vnorm_pkg::MODE_L1 || norm_mode_q == vnorm_pkg::MODE_L2) begin
            cap = (norm_mode_q == vnorm_pkg::MODE_L1) ? L1_CAP : L2_CAP;
            sum = total_q + ((norm_mode_q == vnorm_pkg::MODE_L1) ? 64'(px)
                                                                 : 64'(px) * 64'(px));
            if (sum > cap) begin
                sum       = cap;
                clamped_q = 1'b1;
            end
            total_q = sum & TOTAL_MAX;
        end else if (64'(px) > total_q) begin
            total_q = 64'(px);
        end
        if (!last) return 1'b0;
        sat = clamped_q;
        if (norm_mode_q == vnorm_pkg::MODE_L2) begin
            val = fixed_root(total_q);
        end else if (total_q > (OUT_MAX >> FRAC)) begin
            val = OUT_MAX;
            sat = 1'b1;
        end else begin
            val = total_q << FRAC;
        end
        if (val > OUT_MAX) begin
            val = OUT_MAX;
            sat = 1'b1;
        end
        res.norm  = val[vnorm_pkg::OUT_W-1:0];
        res.sat   = sat;
        total_q   = '0;
        clamped_q = 1'b0;
        return 1'b1;
    endfunction

    // offer one item after random idle cycles, predict once it is taken
    task automatic send_sample(input logic [7:0] px, input logic last,
                               input logic typed_ok, input t_norm_result typed);
        t_norm_result res;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= px;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (o_s_tready !== 1'b1) @(posedge i_clk);
        if (predict_norm(px, last, res))
            expected_norms.push_back(typed_ok ? typed : res);
        @(negedge i_clk);
    endtask

    // write the mode once all results are out and the root step has settled
    task automatic set_mode(input logic [vnorm_pkg::MODE_W-1:0] mode);
        i_s_tvalid <= 1'b0;
        while (expected_norms.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mode;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        norm_mode_q    = mode;
    endtask

    // receiver: random stalls plus an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left   = hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // result scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready) begin
            if (expected_norms.size() == 0) begin
                $display("%0t: result with none expected: norm=%h sat=%b",
                         $time, o_m_tdata, o_m_tuser[0]);
                failed = 1'b1;
            end else begin
                head_norm = expected_norms.pop_front();
                if (o_m_tdata !== head_norm.norm) begin
                    $display("%0t: norm_value expected %h actual %h",
                             $time, head_norm.norm, o_m_tdata);
                    failed = 1'b1;
                end
                if (o_m_tuser[0] !== head_norm.sat) begin
                    $display("%0t: saturated expected %b actual %b",
                             $time, head_norm.sat, o_m_tuser[0]);
                    failed = 1'b1;
                end
            end
        end
    end

    // stimulus
    initial begin
        t_norm_result typed_res;
        int unsigned  sent;
        int unsigned  frames;
        int unsigned  len;
        int unsigned  pick;
        logic         all_max;
        logic [7:0]   px;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        for (int r = 0; r < N_ROWS; r++) begin
            if (DIRECTED[r].cfg_en) set_mode(DIRECTED[r].mode);
            typed_res.norm = DIRECTED[r].norm;
            typed_res.sat  = 1'b0;
            send_sample(DIRECTED[r].px, DIRECTED[r].last, DIRECTED[r].known, typed_res);
        end

        // random frames under four idling phases
        for (int ph = 0; ph < 4; ph++) begin
            unique case (ph)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 64; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 64; end
                default: begin src_idle_pct = 12; sink_stall_pct = 12; end
            endcase
            sent   = 0;
            frames = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 3) == 0) set_mode(2'($urandom_range(0, 3)));
                // long receiver hold while the sender keeps going
                if (ph == 0 && frames == 2) hold_req = 1'b1;
                len     = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 120)
                                                       : $urandom_range(1, 8);
                all_max = ($urandom_range(0, 9) == 0);
                for (int k = 0; k < len; k++) begin
                    if (k != 0 && $urandom_range(0, 29) == 0)
                        set_mode(2'($urandom_range(0, 3)));
                    pick = $urandom_range(0, 9);
                    if (all_max || pick == 1) px = 8'd255;
                    else if (pick == 0)       px = 8'd0;
                    else                      px = 8'($urandom_range(0, 255));
                    send_sample(px, k == len - 1, 1'b0, '0);
                end
                sent   += len;
                frames += 1;
            end
        end

        // drain and check for stray results
        i_s_tvalid <= 1'b0;
        while (expected_norms.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (!failed)
            $display("vector_norm_l1_l2_inf_unit: match");
        else
            $display("vector_norm_l1_l2_inf_unit: mismatch");
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("vector_norm_l1_l2_inf_unit: mismatch");
        $finish;
    end

endmodule

### vector_norm_l1_l2_inf_unit.f
hdl/vnorm_pkg.sv
hdl/vector_norm_l1_l2_inf_unit.sv
verif/tb.sv
